/* rtl/cmpd_pkg.sv */
// Package for the cast message protobuf decoder.
// Holds field and error codes, parser phase type, result struct and capacity helpers.
// No dependencies.
package cmpd_pkg;

    localparam int unsigned SOURCE_CAP    = 128;
    localparam int unsigned DEST_CAP      = 128;
    localparam int unsigned NAMESPACE_CAP = 128;
    localparam int unsigned PAYLOAD_CAP   = 4096;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // protobuf field numbers of the streamed strings
    localparam logic [31:0] TAG_SOURCE    = 32'd2;
    localparam logic [31:0] TAG_DEST      = 32'd3;
    localparam logic [31:0] TAG_NAMESPACE = 32'd4;
    localparam logic [31:0] TAG_PAYLOAD   = 32'd6;

    // output field codes
    localparam logic [2:0] FLD_NONE      = 3'd0;
    localparam logic [2:0] FLD_SOURCE    = 3'd1;
    localparam logic [2:0] FLD_DEST      = 3'd2;
    localparam logic [2:0] FLD_NAMESPACE = 3'd3;
    localparam logic [2:0] FLD_PAYLOAD   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TRUNC    = 3'd1;
    localparam logic [2:0] ERR_LONG     = 3'd2;
    localparam logic [2:0] ERR_WIRE     = 3'd3;
    localparam logic [2:0] ERR_STR_LONG = 3'd4;
    localparam logic [2:0] ERR_MISSING  = 3'd5;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VARVAL = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_STR    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] out_field;
        logic       byte_valid;
        logic       field_start;
        logic       msg_done;
        logic       msg_ok;
        logic [2:0] err_code;
    } res_t;

    function automatic logic [2:0] field_code(input logic [31:0] num);
        logic [2:0] code;
        code = FLD_NONE;
        if (num == TAG_SOURCE)
            code = FLD_SOURCE;
        else if (num == TAG_DEST)
            code = FLD_DEST;
        else if (num == TAG_NAMESPACE)
            code = FLD_NAMESPACE;
        else if (num == TAG_PAYLOAD)
            code = FLD_PAYLOAD;
        return code;
    endfunction

    function automatic logic [63:0] field_cap(input logic [2:0] code);
        logic [63:0] cap;
        if (code == FLD_SOURCE)
            cap = 64'(SOURCE_CAP);
        else if (code == FLD_DEST)
            cap = 64'(DEST_CAP);
        else if (code == FLD_NAMESPACE)
            cap = 64'(NAMESPACE_CAP);
        else
            cap = 64'(PAYLOAD_CAP);
        return cap;
    endfunction

endpackage

/* rtl/cmpd_if.sv */
// Valid/ready channel interfaces for the decoder: byte input and result output.
// Depends on cmpd_pkg.
interface cmpd_in_if
    import cmpd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface cmpd_out_if
    import cmpd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] out_field;
    logic       byte_valid;
    logic       field_start;
    logic       msg_done;
    logic       msg_ok;
    logic [2:0] err_code;

    modport source (output valid, output out_byte, output out_field, output byte_valid,
                    output field_start, output msg_done, output msg_ok, output err_code,
                    input ready);
    modport sink   (input valid, input out_byte, input out_field, input byte_valid,
                    input field_start, input msg_done, input msg_ok, input err_code,
                    output ready);
endinterface

/* rtl/cmpd_parser.sv */
// Wire format parser: holds the decode state and computes one result per accepted byte.
// Depends on cmpd_pkg.
module cmpd_parser
    import cmpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output res_t       res
);

    phase_t      phase_reg, phase_next, phase_cur;
    logic [3:0]  seen_reg, seen_next, seen_inc;
    logic [63:0] acc_reg, acc_next, acc_val, shifted;
    logic [5:0]  shamt;
    logic [2:0]  target_reg, target_next;
    logic [63:0] owed_reg, owed_next, owed_dec;
    logic [3:0]  flags_reg, flags_next;
    logic        fbp_reg, fbp_next;
    logic [2:0]  err_reg, err_next, err_fin;
    logic [1:0]  tidx;

    always_comb
    begin
        unique case (phase_reg)
            PH_VARVAL, PH_LEN, PH_SKIP, PH_STR: phase_cur = phase_reg;
            default:                            phase_cur = PH_TAG;
        endcase
    end

    assign shamt    = 6'({2'b00, seen_reg} * 6'd7);
    assign shifted  = {56'd0, 1'b0, in_byte[6:0]} << shamt;
    assign acc_val  = acc_reg | shifted;
    assign seen_inc = seen_reg + 4'd1;
    assign owed_dec = (owed_reg == 64'd0) ? 64'd0 : owed_reg - 64'd1;
    assign tidx     = 2'(target_reg - 3'd1);

    always_comb
    begin
        phase_next  = phase_cur;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        target_next = target_reg;
        owed_next   = owed_reg;
        flags_next  = flags_reg;
        fbp_next    = fbp_reg;
        err_next    = err_reg;
        err_fin     = ERR_NONE;
        res         = '0;

        if (err_reg == ERR_NONE)
        begin
            priority if (phase_cur == PH_SKIP)
            begin
                owed_next = owed_dec;
                if (owed_dec == 64'd0)
                    phase_next = PH_TAG;
            end
            else if (phase_cur == PH_STR)
            begin
                if (target_reg != FLD_NONE && target_reg <= FLD_PAYLOAD)
                begin
                    res.out_byte   = in_byte;
                    res.out_field  = target_reg;
                    res.byte_valid = 1'b1;
                    if (fbp_reg)
                    begin
                        if (in_byte != 8'd0)
                            flags_next[tidx] = 1'b1;
                        fbp_next = 1'b0;
                    end
                end
                owed_next = owed_dec;
                if (owed_dec == 64'd0)
                begin
                    phase_next  = PH_TAG;
                    target_next = FLD_NONE;
                end
            end
            else
            begin
                // varint byte: tag, varint value or length
                acc_next  = acc_val;
                seen_next = seen_inc;
                if (!in_byte[7])
                begin
                    acc_next  = 64'd0;
                    seen_next = 4'd0;
                    priority if (phase_cur == PH_VARVAL)
                    begin
                        phase_next = PH_TAG;
                    end
                    else if (phase_cur == PH_LEN)
                    begin
                        if (target_reg != FLD_NONE)
                        begin
                            if (acc_val >= field_cap(target_reg))
                            begin
                                err_next = ERR_STR_LONG;
                            end
                            else
                            begin
                                res.out_field   = target_reg;
                                res.field_start = 1'b1;
                                flags_next[tidx] = 1'b0;
                                if (acc_val == 64'd0)
                                begin
                                    phase_next  = PH_TAG;
                                    target_next = FLD_NONE;
                                end
                                else
                                begin
                                    phase_next = PH_STR;
                                    owed_next  = acc_val;
                                    fbp_next   = 1'b1;
                                end
                            end
                        end
                        else if (acc_val == 64'd0)
                        begin
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            owed_next  = acc_val;
                        end
                    end
                    else
                    begin
                        priority if (acc_val[2:0] == WT_VARINT)
                        begin
                            phase_next = PH_VARVAL;
                        end
                        else if (acc_val[2:0] == WT_FIXED64)
                        begin
                            phase_next = PH_SKIP;
                            owed_next  = 64'd8;
                        end
                        else if (acc_val[2:0] == WT_FIXED32)
                        begin
                            phase_next = PH_SKIP;
                            owed_next  = 64'd4;
                        end
                        else if (acc_val[2:0] == WT_LEN)
                        begin
                            phase_next  = PH_LEN;
                            target_next = field_code(acc_val[34:3]);
                        end
                        else
                        begin
                            err_next = ERR_WIRE;
                        end
                    end
                end
                else if (seen_inc >= VARINT_MAX_BYTES)
                begin
                    err_next = ERR_LONG;
                end
            end
        end

        if (last_byte)
        begin
            priority if (err_next != ERR_NONE)
                err_fin = err_next;
            else if (phase_next != PH_TAG || seen_next != 4'd0)
                err_fin = ERR_TRUNC;
            else if (flags_next != 4'hF)
                err_fin = ERR_MISSING;
            else
                err_fin = ERR_NONE;
            res.msg_done = 1'b1;
            res.msg_ok   = (err_fin == ERR_NONE);
            res.err_code = err_fin;
            // start the next message from scratch
            phase_next  = PH_TAG;
            seen_next   = 4'd0;
            acc_next    = 64'd0;
            target_next = FLD_NONE;
            owed_next   = 64'd0;
            flags_next  = 4'd0;
            fbp_next    = 1'b0;
            err_next    = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            seen_reg   <= 4'd0;
            acc_reg    <= 64'd0;
            target_reg <= FLD_NONE;
            owed_reg   <= 64'd0;
            flags_reg  <= 4'd0;
            fbp_reg    <= 1'b0;
            err_reg    <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            target_reg <= target_next;
            owed_reg   <= owed_next;
            flags_reg  <= flags_next;
            fbp_reg    <= fbp_next;
            err_reg    <= err_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=>
            (phase_reg == PH_TAG && seen_reg == 4'd0 && flags_reg == 4'd0 &&
             err_reg == ERR_NONE))
        else $error("state not cleared after final beat");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !(accept && last_byte)) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed before final beat");

    a_str_target: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STR) |-> (target_reg != FLD_NONE && owed_reg != 64'd0))
        else $error("string phase without target or remaining length");

endmodule

/* rtl/cast_message_protobuf_decoder_core.sv */
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the output register takes a new result
// in the same cycle that the held one is taken, so only a stalled sink slows input.
// Reset: rst_n clears the parse state, error latch and field flags and empties the
// output register; the first beat after reset starts a new message.
// Top level of the decoder; depends on cmpd_pkg, cmpd_if and cmpd_parser.
module cast_message_protobuf_decoder_core
    import cmpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cmpd_in_if.sink     in_ch,
    cmpd_out_if.source  out_ch
);

    logic accept;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    cmpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_ch.in_byte),
        .last_byte (in_ch.last_byte),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = res_reg.out_byte;
    assign out_ch.out_field   = res_reg.out_field;
    assign out_ch.byte_valid  = res_reg.byte_valid;
    assign out_ch.field_start = res_reg.field_start;
    assign out_ch.msg_done    = res_reg.msg_done;
    assign out_ch.msg_ok      = res_reg.msg_ok;
    assign out_ch.err_code    = res_reg.err_code;

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("result beat dropped while stalled");

    a_stall_keeps_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> $stable(res_reg))
        else $error("result beat changed while stalled");

endmodule

/* bench/cast_message_protobuf_decoder_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for cast_message_protobuf_decoder_core: directed and random protobuf
// messages go in as byte beats, and every result beat is checked against a decoder model here.
// Depends on cmpd_pkg, the cmpd_in_if/cmpd_out_if interfaces and the decoder RTL.
module cast_message_protobuf_decoder_core_test
    import cmpd_pkg::*;
();

    localparam int PHASE_BEATS = 240;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    // wire types the decoder must reject
    localparam logic [2:0] WT_GROUP_START = 3'd3;
    localparam logic [2:0] WT_GROUP_END   = 3'd4;
    localparam logic [2:0] WT_UNUSED6     = 3'd6;
    localparam logic [2:0] WT_UNUSED7     = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    typedef enum int {
        PART_SOURCE = 1, PART_DEST, PART_NAMESPACE, PART_PAYLOAD,
        PART_VARINT, PART_FIXED64, PART_FIXED32, PART_OTHER_LEN, PART_REPEAT
    } part_t;

    typedef enum int { BREAK_TRUNC, BREAK_WIRE, BREAK_LONG_VARINT, BREAK_OVER_CAP } break_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    cmpd_in_if  byte_ch();
    cmpd_out_if res_ch();

    cast_message_protobuf_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (res_ch)
    );

    msg_byte_t  stream_q[$];
    res_t       result_q[$];
    logic [7:0] msg_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int beats_in       = 0;
    int mismatches     = 0;
    int cycles         = 0;
    bit in_taken       = 1'b0;
    bit hold_request   = 1'b0;

    // decoder model state
    phase_t      dec_phase;
    logic [3:0]  vint_count;
    logic [63:0] vint_acc;
    logic [2:0]  str_field;
    logic [63:0] bytes_left;
    logic [3:0]  filled;
    logic        first_pending;
    logic [2:0]  err_latched;

    function automatic logic [63:0] string_cap(input logic [2:0] fld);
        case (fld)
            FLD_SOURCE:    return 64'(SOURCE_CAP);
            FLD_DEST:      return 64'(DEST_CAP);
            FLD_NAMESPACE: return 64'(NAMESPACE_CAP);
            default:       return 64'(PAYLOAD_CAP);
        endcase
    endfunction

    function automatic logic [31:0] field_number(input logic [2:0] fld);
        case (fld)
            FLD_SOURCE:    return TAG_SOURCE;
            FLD_DEST:      return TAG_DEST;
            FLD_NAMESPACE: return TAG_NAMESPACE;
            default:       return TAG_PAYLOAD;
        endcase
    endfunction

    task automatic clear_decoder;
        dec_phase     = PH_TAG;
        vint_count    = '0;
        vint_acc      = '0;
        str_field     = FLD_NONE;
        bytes_left    = '0;
        filled        = '0;
        first_pending = 1'b0;
        err_latched   = ERR_NONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lastb, output res_t r);
        logic [63:0] v;
        logic [31:0] num;
        int          shift;
        r = '0;
        if (err_latched == ERR_NONE)
        begin
            case (dec_phase)
                PH_TAG, PH_VARVAL, PH_LEN:
                begin
                    shift = 7 * int'(vint_count);
                    // groups past bit 63 fall off the top
                    if (shift < 64)
                        vint_acc = vint_acc | ({57'd0, b[6:0]} << shift);
                    vint_count = vint_count + 4'd1;
                    if (b[7])
                    begin
                        if (vint_count >= VARINT_MAX_BYTES)
                            err_latched = ERR_LONG;
                    end
                    else
                    begin
                        v          = vint_acc;
                        vint_acc   = '0;
                        vint_count = '0;
                        if (dec_phase == PH_TAG)
                        begin
                            num = v[34:3];
                            case (v[2:0])
                                WT_VARINT:
                                    dec_phase = PH_VARVAL;
                                WT_FIXED64:
                                begin
                                    dec_phase  = PH_SKIP;
                                    bytes_left = 64'd8;
                                end
                                WT_FIXED32:
                                begin
                                    dec_phase  = PH_SKIP;
                                    bytes_left = 64'd4;
                                end
                                WT_LEN:
                                begin
                                    dec_phase = PH_LEN;
                                    case (num)
                                        TAG_SOURCE:    str_field = FLD_SOURCE;
                                        TAG_DEST:      str_field = FLD_DEST;
                                        TAG_NAMESPACE: str_field = FLD_NAMESPACE;
                                        TAG_PAYLOAD:   str_field = FLD_PAYLOAD;
                                        default:       str_field = FLD_NONE;
                                    endcase
                                end
                                default:
                                    err_latched = ERR_WIRE;
                            endcase
                        end
                        else if (dec_phase == PH_VARVAL)
                            dec_phase = PH_TAG;
                        else if (str_field != FLD_NONE)
                        begin
                            if (v >= string_cap(str_field))
                                err_latched = ERR_STR_LONG;
                            else
                            begin
                                r.out_field   = str_field;
                                r.field_start = 1'b1;
                                filled[str_field - 3'd1] = 1'b0;
                                if (v == 0)
                                begin
                                    dec_phase = PH_TAG;
                                    str_field = FLD_NONE;
                                end
                                else
                                begin
                                    dec_phase     = PH_STR;
                                    bytes_left    = v;
                                    first_pending = 1'b1;
                                end
                            end
                        end
                        else if (v == 0)
                            dec_phase = PH_TAG;
                        else
                        begin
                            dec_phase  = PH_SKIP;
                            bytes_left = v;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 64'd1;
                    if (bytes_left == 0)
                        dec_phase = PH_TAG;
                end
                default:
                begin
                    r.out_byte   = b;
                    r.out_field  = str_field;
                    r.byte_valid = 1'b1;
                    // only the first byte of a string decides whether it counts as present
                    if (first_pending)
                    begin
                        if (b != 8'd0)
                            filled[str_field - 3'd1] = 1'b1;
                        first_pending = 1'b0;
                    end
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 64'd1;
                    if (bytes_left == 0)
                    begin
                        dec_phase = PH_TAG;
                        str_field = FLD_NONE;
                    end
                end
            endcase
        end
        if (lastb)
        begin
            r.msg_done = 1'b1;
            if (err_latched != ERR_NONE)
                r.err_code = err_latched;
            else if (dec_phase != PH_TAG || vint_count != 0)
                r.err_code = ERR_TRUNC;
            else if (filled != 4'hF)
                r.err_code = ERR_MISSING;
            else
                r.err_code = ERR_NONE;
            r.msg_ok = (r.err_code == ERR_NONE);
            clear_decoder();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------- message builder

    task automatic put_varint(input logic [63:0] v, input int pad);
        logic [63:0] rest;
        int          groups;
        groups = 1;
        rest   = v >> 7;
        while (rest != 0)
        begin
            groups++;
            rest = rest >> 7;
        end
        groups = groups + pad;
        if (groups > 10)
            groups = 10;
        for (int i = 0; i < groups; i++)
        begin
            msg_bytes.push_back({(i < groups - 1) ? 1'b1 : 1'b0, v[6:0]});
            v = v >> 7;
        end
    endtask

    task automatic put_tag(input logic [31:0] num, input logic [2:0] wt);
        logic [28:0] junk;
        // high tag bits above the 32-bit field number must be dropped by the decoder
        junk = ($urandom_range(0, 7) == 0) ? 29'($urandom) : 29'd0;
        put_varint({junk, num, wt}, ($urandom_range(0, 9) == 0) ? 1 : 0);
    endtask

    task automatic put_string(input logic [2:0] fld, input logic [63:0] len, input bit zero_first);
        put_tag(field_number(fld), WT_LEN);
        put_varint(len, 0);
        for (longint i = 0; i < len; i++)
        begin
            if (i == 0)
                msg_bytes.push_back(zero_first ? 8'd0 : 8'($urandom_range(1, 255)));
            else
                msg_bytes.push_back(8'($urandom));
        end
    endtask

    function automatic logic [63:0] pick_len(input logic [2:0] fld);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 64'($urandom_range(1, 6));
        if (r < 95)
            return 64'($urandom_range(7, 40));
        if (fld == FLD_PAYLOAD)
            return 64'($urandom_range(100, 400));
        return string_cap(fld) - 64'd1;
    endfunction

    function automatic logic [2:0] pick_field();
        case ($urandom_range(0, 3))
            0:       return FLD_SOURCE;
            1:       return FLD_DEST;
            2:       return FLD_NAMESPACE;
            default: return FLD_PAYLOAD;
        endcase
    endfunction

    task automatic put_part(input part_t p);
        logic [31:0] num;
        logic [2:0]  fld;
        int          len;
        case (p)
            PART_SOURCE:    put_string(FLD_SOURCE, pick_len(FLD_SOURCE), $urandom_range(0, 19) == 0);
            PART_DEST:      put_string(FLD_DEST, pick_len(FLD_DEST), $urandom_range(0, 19) == 0);
            PART_NAMESPACE:
                put_string(FLD_NAMESPACE, pick_len(FLD_NAMESPACE), $urandom_range(0, 19) == 0);
            PART_PAYLOAD:   put_string(FLD_PAYLOAD, pick_len(FLD_PAYLOAD), $urandom_range(0, 19) == 0);
            PART_VARINT:
            begin
                put_tag($urandom_range(0, 20), WT_VARINT);
                put_varint({$urandom, $urandom} >> $urandom_range(0, 63),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            end
            PART_FIXED64:
            begin
                put_tag($urandom_range(0, 20), WT_FIXED64);
                repeat (8) msg_bytes.push_back(8'($urandom));
            end
            PART_FIXED32:
            begin
                put_tag($urandom_range(0, 20), WT_FIXED32);
                repeat (4) msg_bytes.push_back(8'($urandom));
            end
            PART_OTHER_LEN:
            begin
                num = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
                // steer away from the streamed field numbers
                if (num == TAG_SOURCE || num == TAG_DEST ||
                    num == TAG_NAMESPACE || num == TAG_PAYLOAD)
                    num = num + 32'd8;
                put_tag(num, WT_LEN);
                len = $urandom_range(0, 5);
                put_varint(64'(len), 0);
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
            default:
            begin
                fld = pick_field();
                put_string(fld, 64'($urandom_range(0, 3)), $urandom_range(0, 2) == 0);
            end
        endcase
    endtask

    task automatic put_good_message;
        part_t parts[$];
        part_t t;
        int    j;
        parts = '{PART_SOURCE, PART_DEST, PART_NAMESPACE, PART_PAYLOAD};
        repeat ($urandom_range(0, 3))
            parts.push_back(part_t'($urandom_range(PART_VARINT, PART_REPEAT)));
        for (int i = parts.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = parts[i];
            parts[i] = parts[j];
            parts[j] = t;
        end
        foreach (parts[i])
            put_part(parts[i]);
    endtask

    task automatic put_broken_message;
        logic [2:0] fld;
        int         keep;
        break_t     how;
        put_good_message();
        how = break_t'($urandom_range(BREAK_TRUNC, BREAK_OVER_CAP));
        if (how == BREAK_TRUNC)
        begin
            keep = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > keep)
                void'(msg_bytes.pop_back());
        end
        else
        begin
            // half the time the fault opens the message
            if ($urandom_range(0, 1) == 0)
                msg_bytes.delete();
            case (how)
                BREAK_WIRE:
                begin
                    case ($urandom_range(0, 3))
                        0:       put_tag($urandom_range(0, 20), WT_GROUP_START);
                        1:       put_tag($urandom_range(0, 20), WT_GROUP_END);
                        2:       put_tag($urandom_range(0, 20), WT_UNUSED6);
                        default: put_tag($urandom_range(0, 20), WT_UNUSED7);
                    endcase
                end
                BREAK_LONG_VARINT:
                begin
                    case ($urandom_range(0, 2))
                        0:       ;
                        1:       put_tag($urandom_range(0, 20), WT_VARINT);
                        default: put_tag(field_number(pick_field()), WT_LEN);
                    endcase
                    repeat ($urandom_range(10, 12)) msg_bytes.push_back(8'h80 | 8'($urandom));
                end
                default:
                begin
                    fld = pick_field();
                    put_tag(field_number(fld), WT_LEN);
                    if ($urandom_range(0, 1) == 0)
                        put_varint(string_cap(fld) + 64'($urandom_range(0, 2)), 0);
                    else
                        put_varint({$urandom, $urandom} | 64'h1000_0000, 0);
                end
            endcase
            repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_message;
        foreach (msg_bytes[i])
            stream_q.push_back({msg_bytes[i], i == msg_bytes.size() - 1});
        msg_bytes.delete();
    endtask

    task automatic send_directed;
        // well-formed: source, destination, namespace, payload of one byte each
        msg_bytes = '{8'h12, 8'h01, 8'h61, 8'h1A, 8'h01, 8'hFF,
                      8'h22, 8'h01, 8'h80, 8'h32, 8'h01, 8'h7F};
        send_message();
        // varint tag with its value cut off
        msg_bytes = '{8'h08};
        send_message();
        // field 1 with an unusable wire type
        msg_bytes = '{8'h0F};
        send_message();
        // tag varint still continuing at its tenth byte
        repeat (9) msg_bytes.push_back(8'h80);
        msg_bytes.push_back(8'hFF);
        send_message();
        // empty source string
        msg_bytes = '{8'h12, 8'h00};
        send_message();
        // source length equal to its capacity
        msg_bytes = '{8'h12, 8'h80, 8'h01};
        send_message();
    endtask

    task automatic fill_random(input int target);
        int added;
        int r;
        added = 0;
        while (added < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                put_good_message();
            else if (r < 88)
                put_broken_message();
            else
                repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom));
            added = added + msg_bytes.size();
            send_message();
        end
    endtask

    // ---------------------------------------------------------------- bus processes

    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (!(byte_ch.valid && !in_taken))
        begin
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                byte_ch.valid     <= 1'b1;
                byte_ch.in_byte   <= stream_q[0].data;
                byte_ch.last_byte <= stream_q[0].last;
            end
            else
                byte_ch.valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    always @(negedge clk)
        res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.out_byte    = res_ch.out_byte;
                got.out_field   = res_ch.out_field;
                got.byte_valid  = res_ch.byte_valid;
                got.field_start = res_ch.field_start;
                got.msg_done    = res_ch.msg_done;
                got.msg_ok      = res_ch.msg_ok;
                got.err_code    = res_ch.err_code;
                if (result_q.size() == 0)
                begin
                    $display("%0t: result beat expected none, got %0h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("out_field", 8'(want.out_field), 8'(got.out_field));
                    check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
                    check_field("field_start", 8'(want.field_start), 8'(got.field_start));
                    check_field("msg_done", 8'(want.msg_done), 8'(got.msg_done));
                    check_field("msg_ok", 8'(want.msg_ok), 8'(got.msg_ok));
                    check_field("err_code", 8'(want.err_code), 8'(got.err_code));
                end
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.in_byte, byte_ch.last_byte, want);
                result_q.push_back(want);
                void'(stream_q.pop_front());
                in_taken = 1'b1;
                beats_in++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cast_message_protobuf_decoder_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.in_byte   = 8'd0;
        byte_ch.last_byte = 1'b0;
        res_ch.ready      = 1'b0;
        clear_decoder();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            if (ph == 0)
                send_directed();
            fill_random(PHASE_BEATS);
            if (ph == 0)
            begin
                // block the result side while bytes keep coming, so the core backs up
                wait (beats_in >= 60);
                @(negedge clk);
                hold_request = 1'b1;
                @(negedge clk);
                hold_request = 1'b0;
            end
            // hold the sender until every result of this phase is back
            while (stream_q.size() != 0 || result_q.size() != 0)
                @(posedge clk);
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("cast_message_protobuf_decoder_core: match");
        else
            $display("cast_message_protobuf_decoder_core: mismatch");
        $finish;
    end

endmodule
